@@ rtl/dpet_pkg.sv @@
// Package for the dirty-page epoch tracker: field widths, request codes and
// default geometry. No dependencies; used by the interfaces and all modules.
`timescale 1ns / 1ps

package dpet_pkg;

  // Request payload widths
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned EPOCH_W = 64;

  // Only the low 30 address bits are significant
  localparam int unsigned ADDR_KEEP_W = 30;

  // Default page geometry
  localparam int unsigned PAGE_SHIFT_DEF = 12;
  localparam int unsigned PAGE_COUNT_DEF = 8192;

  // Request codes
  localparam logic REQ_MARK  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

endpackage

@@ rtl/dpet_if.sv @@
// Valid/ready channel interfaces of the dirty-page epoch tracker.
// Depends on dpet_pkg for the payload widths.
`timescale 1ns / 1ps

// Request channel: mark or query a byte range
interface dpet_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [dpet_pkg::ADDR_W-1:0]  address;
  logic [dpet_pkg::LEN_W-1:0]   byte_count;

  modport source (output valid, req_type, address, byte_count, input ready);
  modport sink   (input valid, req_type, address, byte_count, output ready);
endinterface

// Response channel: result of a query
interface dpet_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          range_ok;
  logic [dpet_pkg::EPOCH_W-1:0]  newest_epoch;

  modport source (output valid, range_ok, newest_epoch, input ready);
  modport sink   (input valid, range_ok, newest_epoch, output ready);
endinterface

@@ rtl/dpet_page_mem.sv @@
// Single-port page epoch store, one access per cycle, registered read data.
// Depends on dpet_pkg for the epoch width.
`timescale 1ns / 1ps

module dpet_page_mem #(
  parameter int unsigned DEPTH = dpet_pkg::PAGE_COUNT_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                addr_i,
  input  logic [dpet_pkg::EPOCH_W-1:0] wdata_i,
  output logic [dpet_pkg::EPOCH_W-1:0] rdata_o
);

  logic [dpet_pkg::EPOCH_W-1:0] mem_q [DEPTH];
  logic [dpet_pkg::EPOCH_W-1:0] rdata_q;

  // Write port and registered read port share one address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/dpet_range.sv @@
// Range decoder: masks the address, checks the range against the tracked
// region and gives the first and last page touched. Depends on dpet_pkg.
`timescale 1ns / 1ps

module dpet_range #(
  parameter int unsigned PAGE_SHIFT = dpet_pkg::PAGE_SHIFT_DEF,
  parameter int unsigned PAGE_COUNT = dpet_pkg::PAGE_COUNT_DEF,
  parameter int unsigned PW         = $clog2(PAGE_COUNT)
) (
  input  logic [dpet_pkg::ADDR_W-1:0] address_i,
  input  logic [dpet_pkg::LEN_W-1:0]  byte_count_i,
  output logic                        ok_o,
  output logic [PW-1:0]               first_o,
  output logic [PW-1:0]               last_o
);

  // Wide enough for a 30-bit base plus a 32-bit length and a 2^32 region
  localparam int unsigned SUM_W = 34;
  localparam logic [SUM_W-1:0] REGION = SUM_W'(PAGE_COUNT) << PAGE_SHIFT;

  logic [SUM_W-1:0] base;
  logic [SUM_W-1:0] stop;
  logic [SUM_W-1:0] stop_m1;
  logic [SUM_W-1:0] first_w;
  logic [SUM_W-1:0] last_w;

  // End of range is exclusive; it may sit exactly on the region end
  assign base    = SUM_W'(address_i[dpet_pkg::ADDR_KEEP_W-1:0]);
  assign stop    = base + SUM_W'(byte_count_i);
  assign stop_m1 = stop - SUM_W'(1);

  assign ok_o = (byte_count_i != '0) && (base < REGION) && (stop <= REGION);

  assign first_w = base >> PAGE_SHIFT;
  assign last_w  = stop_m1 >> PAGE_SHIFT;
  assign first_o = first_w[PW-1:0];
  assign last_o  = last_w[PW-1:0];

endmodule

@@ rtl/dirty_page_epoch_tracker.sv @@
// Dirty-page epoch tracker top level: request sequencer, epoch counter,
// result register. Depends on dpet_pkg, dpet_if, dpet_range, dpet_page_mem.
`timescale 1ns / 1ps

// After reset the block sweeps the page store to zero, one page a cycle, and
// takes no request until that is done. Requests are then handled one at a
// time through the single port of the page store, which walks one page per
// cycle: a mark writes each page it touches, a valid query reads each one and
// folds in the last read in its end state, and an invalid request skips the
// walk (an invalid query goes straight to its end state).
// A finished query result sits in an output register, so a new request is
// taken while it waits; a later query holds at its end until that slot frees.

module dirty_page_epoch_tracker #(
  parameter int unsigned PAGE_SHIFT = dpet_pkg::PAGE_SHIFT_DEF,
  parameter int unsigned PAGE_COUNT = dpet_pkg::PAGE_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dpet_req_if.sink          req_i,
  dpet_rsp_if.source        rsp_o
);

  localparam int unsigned PW = $clog2(PAGE_COUNT);
  localparam int unsigned EW = dpet_pkg::EPOCH_W;
  localparam logic [PW-1:0] LAST_PAGE = PW'(PAGE_COUNT - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [PW-1:0] page_q, page_d;
  logic [PW-1:0] last_q, last_d;
  logic          mark_q, mark_d;
  logic          ok_q, ok_d;
  logic          pend_q, pend_d;
  logic [EW-1:0] max_q, max_d;
  logic [EW-1:0] epoch_q, epoch_d;

  logic          out_valid_q;
  logic          out_ok_q;
  logic [EW-1:0] out_epoch_q;
  logic          out_load;

  logic          rng_ok;
  logic [PW-1:0] rng_first;
  logic [PW-1:0] rng_last;

  logic          mem_we;
  logic          mem_re;
  logic [EW-1:0] mem_wdata;
  logic [EW-1:0] mem_rdata;

  logic          accept;
  logic          is_query;
  logic [EW-1:0] cand;

  // Range decode of the incoming request
  dpet_range #(
    .PAGE_SHIFT (PAGE_SHIFT),
    .PAGE_COUNT (PAGE_COUNT),
    .PW         (PW)
  ) u_range (
    .address_i    (req_i.address),
    .byte_count_i (req_i.byte_count),
    .ok_o         (rng_ok),
    .first_o      (rng_first),
    .last_o       (rng_last)
  );

  // Page epoch store
  dpet_page_mem #(
    .DEPTH (PAGE_COUNT),
    .AW    (PW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (page_q),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign is_query    = (req_i.req_type == dpet_pkg::REQ_QUERY);

  // Running maximum, folding in the read issued last cycle
  assign cand = (pend_q && (mem_rdata > max_q)) ? mem_rdata : max_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    page_d    = page_q;
    last_d    = last_q;
    mark_d    = mark_q;
    ok_d      = ok_q;
    pend_d    = pend_q;
    max_d     = max_q;
    epoch_d   = epoch_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = epoch_q;
    out_load  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        page_d    = page_q + PW'(1);
        if (page_q == LAST_PAGE) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          page_d = rng_first;
          last_d = rng_last;
          ok_d   = rng_ok;
          mark_d = !is_query;
          pend_d = 1'b0;
          max_d  = '0;
          if (!is_query) begin
            if (rng_ok) begin
              epoch_d = epoch_q + EW'(1);
              state_d = S_WALK;
            end
          end else if (rng_ok) begin
            state_d = S_WALK;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_WALK: begin
        mem_we = mark_q;
        mem_re = !mark_q;
        pend_d = !mark_q;
        max_d  = cand;
        page_d = page_q + PW'(1);
        if (page_q == last_q) begin
          state_d = mark_q ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        max_d  = cand;
        pend_d = 1'b0;
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      page_q  <= '0;
      mark_q  <= 1'b0;
      pend_q  <= 1'b0;
      epoch_q <= '0;
    end else begin
      state_q <= state_d;
      page_q  <= page_d;
      mark_q  <= mark_d;
      pend_q  <= pend_d;
      epoch_q <= epoch_d;
    end
  end

  // Request payload and running maximum held during the walk
  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    ok_q   <= ok_d;
    max_q  <= max_d;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ok_q    <= ok_q;
      out_epoch_q <= cand;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.range_ok     = out_ok_q;
  assign rsp_o.newest_epoch = out_epoch_q;

  // A result only appears at the end of a query
  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q == S_DONE))
    else $error("response raised outside the query end state");

  // The walk never runs past the last page of the range
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (page_q <= last_q))
    else $error("page walk beyond end of range");

  // The epoch advances only on a valid mark
  a_epoch_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && !is_query && rng_ok) |=> $stable(epoch_q))
    else $error("epoch counter moved without a valid mark");

  // Invalid query results never carry an epoch
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.range_ok) |-> (rsp_o.newest_epoch == '0))
    else $error("invalid range reported a nonzero epoch");

endmodule

@@ bench/dirty_page_epoch_tracker_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for dirty_page_epoch_tracker: a directed table, then random mark
// and query requests; query results are scored against a bench page-stamp predictor
// or the typed directed value. Depends on dpet_pkg, dpet_if and the tracker RTL.

module dirty_page_epoch_tracker_tb;

  localparam int unsigned PAGES       = dpet_pkg::PAGE_COUNT_DEF;
  localparam int unsigned PSHIFT      = dpet_pkg::PAGE_SHIFT_DEF;
  localparam logic [63:0] REGION      = 64'(PAGES) << PSHIFT;
  localparam int unsigned HOT_PAGES   = 24;
  localparam int unsigned N_RANDOM    = 1330;
  localparam int unsigned N_DIRECTED  = 24;
  // Covers the post-reset sweep plus a whole-region walk, several times over
  localparam int unsigned IDLE_LIMIT  = 60000;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned TAIL_CYCLES = 64;

  typedef struct packed {
    logic                         ok;
    logic [dpet_pkg::EPOCH_W-1:0] epoch;
  } scan_t;

  typedef struct {
    logic                        kind;
    logic [dpet_pkg::ADDR_W-1:0] addr;
    logic [dpet_pkg::LEN_W-1:0]  len;
    bit                          typed;
    scan_t                       want;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dpet_req_if req_if ();
  dpet_rsp_if rsp_if ();

  dirty_page_epoch_tracker #(
    .PAGE_SHIFT (PSHIFT),
    .PAGE_COUNT (PAGES)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: one epoch stamp per page and the running mark epoch
  logic [dpet_pkg::EPOCH_W-1:0] page_stamp [PAGES];
  logic [dpet_pkg::EPOCH_W-1:0] mark_epoch;
  scan_t                        expected_scans [$];

  int          n_err;
  int          n_marks;
  int          n_queries;
  int          n_bad_queries;
  int          n_checked;
  bit          calm;
  bit          hold_now;

  // Directed requests; expectations typed in only where obvious
  step_t directed_steps [N_DIRECTED] = '{
    // untouched store straight after reset
    '{dpet_pkg::REQ_QUERY, 32'h0000_0000, 32'h0000_0001, 1'b1, '{1'b1, 64'd0}},
    // zero length
    '{dpet_pkg::REQ_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_MARK,  32'h0000_0000, 32'h0000_0000, 1'b0, '{1'b0, 64'd0}},
    // last byte of the region, then one byte past it
    '{dpet_pkg::REQ_QUERY, 32'h01FF_FFFF, 32'h0000_0001, 1'b1, '{1'b1, 64'd0}},
    '{dpet_pkg::REQ_QUERY, 32'h01FF_FFFF, 32'h0000_0002, 1'b1, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_QUERY, 32'h0200_0000, 32'h0000_0001, 1'b1, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 64'd0}},
    // whole region stamped with epoch 1, read back through ignored top bits
    '{dpet_pkg::REQ_MARK,  32'h0000_0000, 32'h0200_0000, 1'b0, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_QUERY, 32'hC000_0000, 32'h0200_0000, 1'b1, '{1'b1, 64'd1}},
    // straddles pages 0 and 1
    '{dpet_pkg::REQ_MARK,  32'h0000_0FFF, 32'h0000_0002, 1'b0, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_QUERY, 32'h0000_1000, 32'h0000_0001, 1'b0, '{1'b0, 64'd0}},
    // out-of-range mark must not bump the epoch
    '{dpet_pkg::REQ_MARK,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_QUERY, 32'h0000_2000, 32'h0000_0001, 1'b0, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_MARK,  32'h01FF_F000, 32'h0000_1000, 1'b0, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_QUERY, 32'h01FF_FFFF, 32'h0000_0001, 1'b0, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_MARK,  32'h4000_0010, 32'h0000_0010, 1'b0, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_QUERY, 32'h0000_0000, 32'h0000_2000, 1'b0, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_MARK,  32'h3FFF_FFFF, 32'h0000_0001, 1'b0, '{1'b0, 64'd0}},
    // wide mark over half the region
    '{dpet_pkg::REQ_MARK,  32'h8000_3000, 32'h0100_0000, 1'b0, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_QUERY, 32'h0100_0000, 32'h0100_0000, 1'b0, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_QUERY, 32'h0000_0000, 32'h0200_0000, 1'b0, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_QUERY, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_MARK,  32'h0000_0000, 32'h0000_0001, 1'b0, '{1'b0, 64'd0}},
    '{dpet_pkg::REQ_QUERY, 32'h0000_0FFF, 32'h0000_0001, 1'b0, '{1'b0, 64'd0}}
  };

  // Page span of a request; 0 when the range is empty or leaves the region
  function automatic bit span_pages(input logic [dpet_pkg::ADDR_W-1:0] addr,
                                    input logic [dpet_pkg::LEN_W-1:0] len,
                                    output int unsigned first_pg,
                                    output int unsigned last_pg);
    logic [63:0] base;
    logic [63:0] range_end;
    first_pg = 0;
    last_pg  = 0;
    if (len == '0) return 1'b0;
    base      = 64'(addr[dpet_pkg::ADDR_KEEP_W-1:0]);
    range_end = base + 64'(len);
    if (base >= REGION || range_end > REGION) return 1'b0;
    first_pg = int'(base >> PSHIFT);
    last_pg  = int'((range_end - 64'd1) >> PSHIFT);
    return 1'b1;
  endfunction

  // Marks stamp the span with the next epoch; queries scan it for the newest
  task automatic stamp_or_scan(input logic kind,
                               input logic [dpet_pkg::ADDR_W-1:0] addr,
                               input logic [dpet_pkg::LEN_W-1:0] len,
                               output bit has_scan, output scan_t scan);
    int unsigned first_pg;
    int unsigned last_pg;
    bit          ok;
    ok       = span_pages(addr, len, first_pg, last_pg);
    scan     = '0;
    has_scan = 1'b0;
    if (kind == dpet_pkg::REQ_MARK) begin
      if (ok) begin
        mark_epoch = mark_epoch + 64'd1;
        for (int unsigned p = first_pg; p <= last_pg; p++) page_stamp[p] = mark_epoch;
      end
    end else begin
      has_scan = 1'b1;
      scan.ok  = ok;
      if (ok) begin
        for (int unsigned p = first_pg; p <= last_pg; p++)
          if (page_stamp[p] > scan.epoch) scan.epoch = page_stamp[p];
      end
    end
  endtask

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  // Random request, biased towards a few hot pages and the top of the region
  task automatic pick_request(output logic kind,
                              output logic [dpet_pkg::ADDR_W-1:0] addr,
                              output logic [dpet_pkg::LEN_W-1:0] len);
    int unsigned page;
    int unsigned r;
    logic [63:0] base;
    kind = ($urandom_range(99) < 50) ? dpet_pkg::REQ_MARK : dpet_pkg::REQ_QUERY;
    r = $urandom_range(99);
    if (r < 55)      page = $urandom_range(HOT_PAGES - 1);
    else if (r < 70) page = PAGES - 1 - $urandom_range(7);
    else             page = $urandom_range(PAGES - 1);
    addr = {2'($urandom), 30'((page << PSHIFT) + $urandom_range((1 << PSHIFT) - 1))};
    // noise: fully random address, nearly always outside the region
    if (r >= 88) addr = $urandom;
    base = 64'(addr[dpet_pkg::ADDR_KEEP_W-1:0]);
    r = $urandom_range(99);
    if (r < 65)      len = $urandom_range(1 << PSHIFT, 1);
    else if (r < 82) len = $urandom_range(3 << PSHIFT, 1);
    else if (r < 86) len = '0;
    else if (r < 92 && base < REGION && base + (64'd1 << 20) >= REGION)
      len = 32'(REGION - base) + $urandom_range(1);  // exactly to the end, or one over
    else if (r < 95) len = $urandom;
    else if (r < 97) len = $urandom_range(32'(REGION), 1);
    else             len = $urandom_range(64, 1);
  endtask

  // Offer one request, wait for it to be taken, then record what it should give
  task automatic send_req(input logic kind, input logic [dpet_pkg::ADDR_W-1:0] addr,
                          input logic [dpet_pkg::LEN_W-1:0] len, input bit typed,
                          input scan_t typed_scan);
    int unsigned gap;
    bit          has_scan;
    scan_t       scan;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.address    <= addr;
    req_if.byte_count <= len;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    stamp_or_scan(kind, addr, len, has_scan, scan);
    if (has_scan) begin
      expected_scans.push_back(typed ? typed_scan : scan);
      n_queries++;
      if (!scan.ok) n_bad_queries++;
    end else begin
      n_marks++;
    end
  endtask

  // Result side: score each result, stall at random, one long hold-off on demand
  initial begin : result_sink
    int unsigned stall;
    int unsigned hold;
    bit          hold_started;
    scan_t       want;
    stall        = 0;
    hold         = 0;
    hold_started = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_scans.size() == 0) begin
          $error("unexpected result: range_ok=%0d newest_epoch=%0d",
                 rsp_if.range_ok, rsp_if.newest_epoch);
          n_err++;
        end else begin
          want = expected_scans.pop_front();
          n_checked++;
          if (rsp_if.range_ok !== want.ok) begin
            $error("range_ok: expected %0d, got %0d", want.ok, rsp_if.range_ok);
            n_err++;
          end
          if (rsp_if.newest_epoch !== want.epoch) begin
            $error("newest_epoch: expected %0d, got %0d", want.epoch, rsp_if.newest_epoch);
            n_err++;
          end
        end
      end
      if (hold_now && !hold_started) begin
        hold_started = 1'b1;
        hold         = HOLD_CYCLES;
      end
      if (hold != 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else if (calm || $urandom_range(99) < 70) begin
        rsp_if.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        rsp_if.ready <= 1'b0;
      end
    end
  end

  // Ends the run if neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Reset, directed table, random traffic, drain
  initial begin : stimulus
    logic                        kind;
    logic [dpet_pkg::ADDR_W-1:0] addr;
    logic [dpet_pkg::LEN_W-1:0]  len;
    n_err         = 0;
    n_marks       = 0;
    n_queries     = 0;
    n_bad_queries = 0;
    n_checked     = 0;
    calm          = 1'b0;
    hold_now      = 1'b0;
    mark_epoch    = '0;
    for (int p = 0; p < PAGES; p++) page_stamp[p] = '0;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= dpet_pkg::REQ_MARK;
    req_if.address    <= '0;
    req_if.byte_count <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < N_DIRECTED; k++)
      send_req(directed_steps[k].kind, directed_steps[k].addr, directed_steps[k].len,
               directed_steps[k].typed, directed_steps[k].want);

    for (int i = 0; i < N_RANDOM; i++) begin
      // every fourth stretch runs back to back on both sides
      calm = ((i / 160) % 4) == 2;
      // long result hold-off while requests keep coming
      if (i == N_RANDOM / 3) hold_now = 1'b1;
      // sender pauses until all results are in
      if (i == (2 * N_RANDOM) / 3) begin
        req_if.valid <= 1'b0;
        do @(posedge clk_i); while (expected_scans.size() != 0);
      end
      pick_request(kind, addr, len);
      send_req(kind, addr, len, 1'b0, '0);
    end

    req_if.valid <= 1'b0;
    while (expected_scans.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: %0d marks, %0d queries of which %0d out of range.",
             n_marks + n_queries, n_marks, n_queries, n_bad_queries);
    $display("Checked %0d query results; mark epoch reached %0d.", n_checked, mark_epoch);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
